FILE: design/rzs_pkg.sv
// Package for the rolling z-score signal block: sizes, payload structs,
// per-symbol state record, position codes and the sequencer state type.
// Depends on nothing; every module of the block imports it.
package rzs_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int WINDOW       = 64;
  localparam int PRICE_BITS   = 24;

  localparam int SYM_BITS   = 8;
  localparam int TICK_BITS  = 32;
  localparam int CFG_BITS   = 8;
  localparam int MID_BITS   = PRICE_BITS + 1;
  localparam int WIN_BITS   = $clog2(WINDOW);
  localparam int SLOT_BITS  = (WIN_BITS < 1) ? 1 : WIN_BITS;
  localparam int FILL_BITS  = $clog2(WINDOW + 1);
  localparam int SUM_BITS   = MID_BITS + $clog2(WINDOW);
  localparam int SQR_BITS   = 2 * MID_BITS;
  localparam int SSQ_BITS   = SQR_BITS + $clog2(WINDOW);
  localparam int PROD_BITS  = 2 * SUM_BITS;
  localparam int LHS_BITS   = PROD_BITS + 2;
  localparam int THR_BITS   = PROD_BITS + CFG_BITS;
  localparam int ADDR_BITS  = $clog2(SYMBOL_COUNT * WINDOW);
  localparam int SIDX_BITS  = $clog2(SYMBOL_COUNT);

  localparam logic [CFG_BITS-1:0] ENTRY_RESET = 8'd16;
  localparam logic [CFG_BITS-1:0] EXIT_RESET  = 8'd1;

  localparam logic CFG_ENTRY = 1'b0;
  localparam logic CFG_EXIT  = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [1:0] POS_FLAT  = 2'b00;
  localparam logic [1:0] POS_LONG  = 2'b01;
  localparam logic [1:0] POS_SHORT = 2'b11;

  typedef struct packed {
    logic [SYM_BITS-1:0]   symbol;
    logic [PRICE_BITS-1:0] bid_price;
    logic [PRICE_BITS-1:0] ask_price;
    logic [TICK_BITS-1:0]  tick_number;
  } tick_t;

  typedef struct packed {
    logic                  order_side;
    logic [SYM_BITS-1:0]   order_symbol;
    logic [PRICE_BITS-1:0] order_price;
    logic                  order_quantity;
    logic [TICK_BITS-1:0]  order_tick;
  } order_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] entry_zsq_quarters;
    logic [CFG_BITS-1:0] exit_zsq_quarters;
  } thresholds_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]  sum;
    logic [SSQ_BITS-1:0]  sumsq;
    logic [FILL_BITS-1:0] fill;
    logic [SLOT_BITS-1:0] slot;
    logic [1:0]           pos;
  } sym_state_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_WIN, ST_ACC, ST_SUM, ST_MUL1, ST_MUL2, ST_MUL3, ST_DEC
  } seq_state_t;

endpackage

FILE: design/rzs_front.sv
// Front end of the rolling z-score block: takes tick transfers and holds
// them in a two-entry queue for the back end. Depends on rzs_pkg.
module rzs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rzs_pkg::tick_t in_item,
  output logic           q_valid,
  output rzs_pkg::tick_t q_item,
  input  logic           q_pop
);
  import rzs_pkg::*;

  tick_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule

FILE: design/rzs_back.sv
// Back end of the rolling z-score block: per-symbol state and price ring
// memories, the update sequencer, the decision and the order register.
// Depends on rzs_pkg.
module rzs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  rzs_pkg::tick_t       q_item,
  output logic                 q_pop,
  input  rzs_pkg::thresholds_t thr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rzs_pkg::order_t      out_order
);
  import rzs_pkg::*;

  sym_state_t            st_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] sym_valid;
  logic [MID_BITS-1:0]   win_mem [SYMBOL_COUNT * WINDOW];

  seq_state_t state, state_next;

  tick_t                cur;
  logic [MID_BITS-1:0]  mid;
  sym_state_t           st_rdata;
  logic                 st_rvalid;
  sym_state_t           st_cur;
  logic [MID_BITS-1:0]  win_rdata;
  logic [SQR_BITS-1:0]  mid_sq;
  logic [SQR_BITS-1:0]  old_sq;
  logic [MID_BITS-1:0]  old_val;
  logic [SUM_BITS-1:0]  new_sum;
  logic [SSQ_BITS-1:0]  new_sumsq;
  logic [FILL_BITS-1:0] new_fill;
  logic [SLOT_BITS-1:0] new_slot;
  logic [SUM_BITS-1:0]  wm;
  logic [SUM_BITS-1:0]  distance;
  logic                 above;
  logic [PROD_BITS-1:0] sum_sq;
  logic [LHS_BITS-1:0]  lhs;
  logic [PROD_BITS-1:0] var_d;
  logic [THR_BITS-1:0]  entry_thr;
  logic [THR_BITS-1:0]  exit_thr;

  logic                 st_rd_en;
  logic                 win_rd_en;
  logic                 commit;
  logic                 fire;
  logic                 stall;
  logic                 sel_side;
  logic [1:0]           sel_pos;
  logic [ADDR_BITS-1:0] win_addr;
  logic [ADDR_BITS-1:0] wr_addr;
  sym_state_t           st_wdata;

  // Decision from registered values only, so it is stable while stalled.
  always_comb begin
    fire     = 1'b0;
    sel_side = SIDE_BUY;
    sel_pos  = st_cur.pos;
    if (new_fill == FILL_BITS'(WINDOW)) begin
      if (st_cur.pos == POS_FLAT) begin
        if ({{(THR_BITS-LHS_BITS){1'b0}}, lhs} >= entry_thr) begin
          fire     = 1'b1;
          sel_side = above ? SIDE_SELL : SIDE_BUY;
          sel_pos  = above ? POS_SHORT : POS_LONG;
        end
      end else if (exit_thr >= {{(THR_BITS-LHS_BITS){1'b0}}, lhs}) begin
        fire     = 1'b1;
        sel_side = (st_cur.pos == POS_LONG) ? SIDE_SELL : SIDE_BUY;
        sel_pos  = POS_FLAT;
      end
    end
  end

  assign stall = fire && out_valid && !out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid) state_next = ST_READ;
      ST_READ: state_next = ST_WIN;
      ST_WIN:  state_next = ST_ACC;
      ST_ACC:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_DEC;
      ST_DEC:  if (!stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    st_rd_en  = 1'b0;
    win_rd_en = 1'b0;
    commit    = 1'b0;
    case (state)
      ST_IDLE: q_pop     = q_valid;
      ST_READ: st_rd_en  = 1'b1;
      ST_WIN:  win_rd_en = 1'b1;
      ST_DEC:  commit    = !stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // A symbol never written since reset reads as all-zero state.
  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= '0;
    end else if (commit) begin
      sym_valid[SIDX_BITS'(cur.symbol)] <= 1'b1;
    end
  end

  assign st_wdata = '{sum: new_sum, sumsq: new_sumsq, fill: new_fill,
                      slot: new_slot, pos: sel_pos};

  always_ff @(posedge clk) begin
    if (st_rd_en) begin
      st_rdata  <= st_mem[SIDX_BITS'(cur.symbol)];
      st_rvalid <= sym_valid[SIDX_BITS'(cur.symbol)];
    end
    if (commit) st_mem[SIDX_BITS'(cur.symbol)] <= st_wdata;
  end

  assign win_addr = ADDR_BITS'(ADDR_BITS'(cur.symbol) * ADDR_BITS'(WINDOW)
                    + ADDR_BITS'(st_rvalid ? st_rdata.slot : '0));
  assign wr_addr  = ADDR_BITS'(ADDR_BITS'(cur.symbol) * ADDR_BITS'(WINDOW)
                    + ADDR_BITS'(st_cur.slot));

  always_ff @(posedge clk) begin
    if (win_rd_en) win_rdata <= win_mem[win_addr];
    if (commit)    win_mem[wr_addr] <= mid;
  end

  // Slots past the fill count have never been written and count as zero.
  assign old_val = (st_cur.fill < FILL_BITS'(WINDOW)) ? '0 : win_rdata;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur <= q_item;
        mid <= MID_BITS'(q_item.bid_price) + MID_BITS'(q_item.ask_price);
      end
      ST_WIN: begin
        st_cur <= st_rvalid ? st_rdata : '0;
        mid_sq <= SQR_BITS'(mid) * SQR_BITS'(mid);
      end
      ST_ACC: begin
        old_sq <= SQR_BITS'(old_val) * SQR_BITS'(old_val);
        new_sum <= st_cur.sum - SUM_BITS'(old_val) + SUM_BITS'(mid);
      end
      ST_SUM: begin
        new_sumsq <= st_cur.sumsq - SSQ_BITS'(old_sq) + SSQ_BITS'(mid_sq);
        new_fill  <= (st_cur.fill < FILL_BITS'(WINDOW)) ?
                     st_cur.fill + FILL_BITS'(1) : st_cur.fill;
        new_slot  <= (32'(st_cur.slot) + 32'd1 >= 32'(WINDOW)) ?
                     '0 : st_cur.slot + SLOT_BITS'(1);
        wm        <= SUM_BITS'(SUM_BITS'(mid) * SUM_BITS'(WINDOW));
      end
      ST_MUL1: begin
        above    <= (wm > new_sum);
        distance <= (wm > new_sum) ? wm - new_sum : new_sum - wm;
        sum_sq   <= PROD_BITS'(new_sum) * PROD_BITS'(new_sum);
      end
      ST_MUL2: begin
        lhs   <= {PROD_BITS'(distance) * PROD_BITS'(distance), 2'b00};
        var_d <= PROD_BITS'(PROD_BITS'(new_sumsq) * PROD_BITS'(WINDOW)) - sum_sq;
      end
      ST_MUL3: begin
        entry_thr <= THR_BITS'(var_d) * THR_BITS'(thr.entry_zsq_quarters);
        exit_thr  <= THR_BITS'(var_d) * THR_BITS'(thr.exit_zsq_quarters);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && fire) begin
      out_order.order_side     <= sel_side;
      out_order.order_symbol   <= cur.symbol;
      out_order.order_price    <= (sel_side == SIDE_SELL) ? cur.bid_price : cur.ask_price;
      out_order.order_quantity <= 1'b1;
      out_order.order_tick     <= cur.tick_number;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> st_cur.fill <= FILL_BITS'(WINDOW))
    else $error("fill count above window");

  a_fire_full: assert property (@(posedge clk) disable iff (rst)
    commit && fire |-> new_fill == FILL_BITS'(WINDOW))
    else $error("order raised before window filled");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == ST_READ)
    else $error("queue pop did not start a sequence");

endmodule

FILE: design/rolling_zscore_signal_top.sv
// Top level of the rolling z-score mean-reversion signal block.
// Holds the threshold registers and joins rzs_front and rzs_back; uses rzs_pkg.
//
// Usage: ticks arrive as transfers on in_valid/in_ready with in_item
// (symbol, bid, ask, tick number). Orders leave as transfers on
// out_valid/out_ready with out_order. A tick yields zero or one order.
// The two thresholds are written through cfg_we/cfg_index/cfg_data while
// the block is idle: index 0 is the entry level, index 1 the exit level.
//
// Each tick is worked through by the sequencer in the back end, which
// reads the symbol's state, reads the price ring, updates sums, runs three
// rounds of multiplication and commits; one tick is worked on at a time,
// so the back end takes no new tick before the last one has committed.
// The order is registered when the tick commits. A two-entry queue
// in front keeps taking ticks while the back end is busy.
//
// Reset clears all per-symbol state at once through valid bits and the
// fill count, so no clearing pass is needed. If the receiver stalls with
// an order pending, the back end waits before committing the next order.
module rolling_zscore_signal_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rzs_pkg::tick_t                   in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rzs_pkg::order_t                  out_order,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [rzs_pkg::CFG_BITS-1:0]     cfg_data
);
  import rzs_pkg::*;

  thresholds_t thr;
  logic        q_valid;
  tick_t       q_item;
  logic        q_pop;

  // Threshold registers: the user is to write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.entry_zsq_quarters <= ENTRY_RESET;
      thr.exit_zsq_quarters  <= EXIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRY: thr.entry_zsq_quarters <= cfg_data;
        CFG_EXIT:  thr.exit_zsq_quarters  <= cfg_data;
        default:   ;
      endcase
    end
  end

  rzs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  rzs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .thr       (thr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_order (out_order)
  );

endmodule

FILE: tb/tb_rolling_zscore_signal_top.sv
// Testbench for the rolling z-score signal block: drives ticks, predicts the
// orders with its own integer model of the per-symbol windows and compares.
// Depends on rzs_pkg and rolling_zscore_signal_top.
`timescale 1ns / 1ps

module tb_rolling_zscore_signal_top;
  import rzs_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  tick_t in_item;
  logic out_valid;
  logic out_ready;
  order_t out_order;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  rolling_zscore_signal_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_order(out_order),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the per-symbol state; the ring and the sums are held at the block's widths.
  logic [MID_BITS-1:0]  ring_mid [SYMBOL_COUNT*WINDOW];
  logic [SUM_BITS-1:0]  mid_sum [SYMBOL_COUNT];
  logic [SSQ_BITS-1:0]  mid_sumsq [SYMBOL_COUNT];
  int unsigned          fill_cnt [SYMBOL_COUNT];
  int unsigned          next_slot [SYMBOL_COUNT];
  logic [1:0]           position [SYMBOL_COUNT];
  logic [CFG_BITS-1:0]  entry_level;
  logic [CFG_BITS-1:0]  exit_level;

  order_t pending_orders[$];
  int     mismatches;
  longint cycle_count;

  // Idling percentages, changed between phases.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  bit          recv_hold;
  int unsigned tick_seq;

  localparam longint CYCLE_LIMIT = 400000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  task automatic clear_shadow();
    for (int i = 0; i < SYMBOL_COUNT*WINDOW; i++) ring_mid[i] = '0;
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      mid_sum[i] = '0;
      mid_sumsq[i] = '0;
      fill_cnt[i] = 0;
      next_slot[i] = 0;
      position[i] = POS_FLAT;
    end
    entry_level = ENTRY_RESET;
    exit_level = EXIT_RESET;
  endtask

  // Works out the order, if any, that one accepted tick causes.
  task automatic predict_order(input tick_t t);
    int unsigned sym;
    int unsigned slot;
    logic [MID_BITS-1:0] mid;
    logic [MID_BITS-1:0] old_mid;
    logic [127:0] wm;
    logic [127:0] s;
    logic [127:0] distance;
    logic [127:0] lhs;
    logic [127:0] var_d;
    logic [127:0] thr;
    order_t o;
    sym = 32'(t.symbol);
    mid = MID_BITS'(t.bid_price) + MID_BITS'(t.ask_price);
    slot = next_slot[sym];
    old_mid = ring_mid[sym*WINDOW + slot];
    ring_mid[sym*WINDOW + slot] = mid;
    next_slot[sym] = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    mid_sum[sym] = mid_sum[sym] - old_mid + mid;
    mid_sumsq[sym] = mid_sumsq[sym] - SSQ_BITS'(old_mid) * SSQ_BITS'(old_mid)
                     + SSQ_BITS'(mid) * SSQ_BITS'(mid);
    if (fill_cnt[sym] < WINDOW) fill_cnt[sym]++;
    if (fill_cnt[sym] < WINDOW) return;
    s = 128'(mid_sum[sym]);
    wm = 128'(WINDOW) * 128'(mid);
    distance = (wm > s) ? wm - s : s - wm;
    lhs = 128'(4) * distance * distance;
    var_d = 128'(WINDOW) * 128'(mid_sumsq[sym]) - s * s;
    o.order_symbol = t.symbol;
    o.order_quantity = 1'b1;
    o.order_tick = t.tick_number;
    if (position[sym] == POS_FLAT) begin
      thr = var_d * 128'(entry_level);
      if (lhs < thr) return;
      if (wm > s) begin
        o.order_side = SIDE_SELL;
        position[sym] = POS_SHORT;
      end else begin
        o.order_side = SIDE_BUY;
        position[sym] = POS_LONG;
      end
    end else begin
      thr = var_d * 128'(exit_level);
      if (thr < lhs) return;
      o.order_side = (position[sym] == POS_LONG) ? SIDE_SELL : SIDE_BUY;
      position[sym] = POS_FLAT;
    end
    o.order_price = (o.order_side == SIDE_SELL) ? t.bid_price : t.ask_price;
    pending_orders.push_back(o);
  endtask

  // Sends one tick: optional random gap with valid low, then valid held
  // until the transfer. Valid is dropped by the next gap or by the drain.
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_order(t);
  endtask

  // Receiver side: random stalls, checks each order transfer against the
  // oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_orders.size() == 0) begin
          report_mismatch("unexpected order", 64'(out_order.order_tick), '0);
        end else begin
          order_t e;
          e = pending_orders.pop_front();
          if (out_order.order_side !== e.order_side)
            report_mismatch("side", 64'(out_order.order_side), 64'(e.order_side));
          if (out_order.order_symbol !== e.order_symbol)
            report_mismatch("symbol", 64'(out_order.order_symbol),
                            64'(e.order_symbol));
          if (out_order.order_price !== e.order_price)
            report_mismatch("price", 64'(out_order.order_price), 64'(e.order_price));
          if (out_order.order_quantity !== e.order_quantity)
            report_mismatch("quantity", 64'(out_order.order_quantity),
                            64'(e.order_quantity));
          if (out_order.order_tick !== e.order_tick)
            report_mismatch("tick", 64'(out_order.order_tick), 64'(e.order_tick));
        end
      end
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_orders.size() != 0) @(posedge clk);
    // Ticks that make no order may still be in flight.
    repeat (40) @(posedge clk);
  endtask

  task automatic write_level(input logic idx, input logic [CFG_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ENTRY) entry_level = val;
    else exit_level = val;
    @(posedge clk);
  endtask

  function automatic tick_t make_tick(input int unsigned sym,
                                      input logic [PRICE_BITS-1:0] bid,
                                      input logic [PRICE_BITS-1:0] ask);
    tick_t t;
    t.symbol = sym[SYM_BITS-1:0];
    t.bid_price = bid;
    t.ask_price = ask;
    t.tick_number = {tick_seq[15:0], 16'($urandom())};
    return t;
  endfunction

  // Directed: extreme prices and extreme symbols, tick number extremes.
  task automatic test_directed();
    tick_t t;
    t = make_tick(0, '1, '1);
    t.tick_number = '1;
    send_tick(t);
    t = make_tick(255, '0, '0);
    t.tick_number = '0;
    send_tick(t);
    t = make_tick(255, '1, 24'h000001);
    send_tick(t);
    wait_drained();
  endtask

  // Fills one symbol's window with a constant mid: a zero variance window.
  task automatic test_zero_variance();
    for (int i = 0; i < 66; i++) send_tick(make_tick(7, 24'd1000, 24'd1002));
  endtask

  // Well-formed runs: a symbol's window is filled around a base price, then
  // spikes and returns drive entries and exits. Noise ticks are mixed in.
  task automatic test_random(input int count, input int nsyms);
    int unsigned sym;
    int unsigned base;
    logic [PRICE_BITS-1:0] bid;
    logic [PRICE_BITS-1:0] ask;
    for (int i = 0; i < count; i++) begin
      tick_seq++;
      sym = $urandom_range(nsyms - 1);
      base = (sym * 65537 + 4096) & 24'hffffff;
      case ($urandom_range(9))
        0: begin
          bid = PRICE_BITS'($urandom());
          ask = PRICE_BITS'($urandom());
        end
        1: begin
          bid = PRICE_BITS'(base + $urandom_range(60000));
          ask = PRICE_BITS'(bid + 2);
        end
        2: begin
          bid = PRICE_BITS'((base > 60000) ? base - $urandom_range(60000) : 0);
          ask = PRICE_BITS'(bid + 2);
        end
        default: begin
          bid = PRICE_BITS'(base + $urandom_range(40));
          ask = PRICE_BITS'(bid + $urandom_range(4));
        end
      endcase
      if ($urandom_range(99) == 0) begin
        bid = '1;
        ask = '1;
      end
      send_tick(make_tick(sym, bid, ask));
    end
  endtask

  // Receiver stops for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (600) @(posedge clk);
        recv_hold = 1'b0;
      end
      begin
        test_random(120, 2);
        wait_drained();
      end
    join
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ENTRY;
    cfg_data = '0;
    mismatches = 0;
    cycle_count = 0;
    send_gap_pct = 13;
    recv_stall_pct = 49;
    recv_hold = 1'b0;
    tick_seq = 0;
    clear_shadow();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_zero_variance();
    wait_drained();
    test_random(350, 4);
    wait_drained();

    write_level(CFG_ENTRY, 8'd0);
    write_level(CFG_EXIT, 8'd255);
    send_gap_pct = 49;
    recv_stall_pct = 13;
    test_random(350, 3);
    wait_drained();

    write_level(CFG_ENTRY, 8'd255);
    write_level(CFG_EXIT, 8'd0);
    test_random(200, 4);
    wait_drained();

    write_level(CFG_ENTRY, 8'd4);
    write_level(CFG_EXIT, 8'd2);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random(300, 3);
    test_backpressure();

    @(posedge clk);
    if (mismatches == 0 && pending_orders.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
